// ===== rtl/pas_pkg.sv =====
// Shared types and constants for the priority aging scheduler.
package pas_pkg;

  localparam int unsigned MAX_TASKS_DEF = 16;
  localparam int unsigned NSLOTS = 16;
  localparam int unsigned SLOT_W = 4;
  localparam int unsigned SPRIO_W = 6;
  localparam int unsigned DPRIO_W = 8;
  localparam int unsigned STEP_W = 4;
  localparam int unsigned QUANT_W = 8;
  localparam int unsigned KIND_W = 3;
  localparam int unsigned STAT_W = 3;
  localparam int unsigned CFG_IDX_W = 1;
  localparam int unsigned CFG_DATA_W = 8;

  localparam logic [STEP_W-1:0]  AGING_RESET = 4'd1;
  localparam logic [QUANT_W-1:0] QUANT_RESET = 8'd20;
  localparam logic signed [SPRIO_W-1:0] PRIO_MIN = -6'sd19;
  localparam logic signed [SPRIO_W-1:0] PRIO_MAX = 6'sd19;
  localparam logic signed [DPRIO_W-1:0] DYN_FLOOR = -8'sd128;

  localparam logic [KIND_W-1:0] KIND_ADD    = 3'd0;
  localparam logic [KIND_W-1:0] KIND_REMOVE = 3'd1;
  localparam logic [KIND_W-1:0] KIND_SETPRI = 3'd2;
  localparam logic [KIND_W-1:0] KIND_SCHED  = 3'd3;
  localparam logic [KIND_W-1:0] KIND_TICK   = 3'd4;

  localparam logic [STAT_W-1:0] ST_OK      = 3'd0;
  localparam logic [STAT_W-1:0] ST_BADPRI  = 3'd1;
  localparam logic [STAT_W-1:0] ST_FULL    = 3'd2;
  localparam logic [STAT_W-1:0] ST_NOTASK  = 3'd3;
  localparam logic [STAT_W-1:0] ST_SLOT    = 3'd4;

  localparam logic [CFG_IDX_W-1:0] CFG_AGING   = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_QUANTUM = 1'd1;

endpackage

// ===== rtl/pas_order.sv =====
// Ready list memory in insertion order, with one read port and one write port.
module pas_order #(
  parameter int unsigned DEPTH = pas_pkg::NSLOTS
) (
  input  logic                        clk,
  input  logic                        we,
  input  logic [$clog2(DEPTH)-1:0]    waddr,
  input  logic [pas_pkg::SLOT_W-1:0]  wdata,
  input  logic [$clog2(DEPTH)-1:0]    raddr,
  output logic [pas_pkg::SLOT_W-1:0]  rdata
);

  logic [pas_pkg::SLOT_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/priority_aging_scheduler_core.sv =====
// Priority aging scheduler: task table, ready list walk and tick counter.
// Add, set priority, tick and unused kinds go through the execute and readback states;
// remove walks the ready list once, schedule twice (a minimum search pass and an aging
// pass), each entry taking a read state and an update state. Busy stays high meanwhile.
// Requests are taken one at a time, accepted in the done cycle; results cannot stall.
// Reset (rst, synchronous) clears all tasks; aging_step resets to 1, quantum to 20.
module priority_aging_scheduler_core #(
  parameter int unsigned MAX_TASKS = pas_pkg::MAX_TASKS_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                start,
  output logic                                busy,
  input  logic [pas_pkg::KIND_W-1:0]          kind,
  input  logic [pas_pkg::SLOT_W-1:0]          slot,
  input  logic                                use_current,
  input  logic signed [pas_pkg::SPRIO_W-1:0]  prio,
  input  logic                                cfg_we,
  input  logic [pas_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [pas_pkg::CFG_DATA_W-1:0]      cfg_data,
  output logic                                done,
  output logic [pas_pkg::STAT_W-1:0]          status,
  output logic                                chosen_valid,
  output logic [pas_pkg::SLOT_W-1:0]          chosen_slot,
  output logic                                preempt,
  output logic signed [pas_pkg::SPRIO_W-1:0]  prio_readback
);

  localparam int unsigned LIST_DEPTH =
      (MAX_TASKS < pas_pkg::NSLOTS) ? MAX_TASKS : pas_pkg::NSLOTS;
  localparam int unsigned IDX_W = $clog2(LIST_DEPTH);
  localparam int unsigned CNT_W = $clog2(LIST_DEPTH + 1);
  localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(LIST_DEPTH);

  typedef enum logic [3:0] {
    S_IDLE, S_EXEC, S_MIN_RD, S_MIN_CMP, S_AGE_RD, S_AGE_UPD,
    S_RM_RD, S_RM_MOV, S_READBACK
  } state_t;

  state_t state;
  logic [pas_pkg::KIND_W-1:0] op_kind;
  logic [pas_pkg::SLOT_W-1:0] op_slot;
  logic op_cur;
  logic signed [pas_pkg::SPRIO_W-1:0] op_prio;

  logic signed [pas_pkg::SPRIO_W-1:0] static_prio [pas_pkg::NSLOTS];
  logic signed [pas_pkg::DPRIO_W-1:0] dynamic_prio [pas_pkg::NSLOTS];
  logic [pas_pkg::NSLOTS-1:0] slot_present;
  logic [CNT_W-1:0] task_count;
  logic [pas_pkg::SLOT_W-1:0] running_slot;
  logic running_valid;
  logic [pas_pkg::QUANT_W-1:0] quantum_left;
  logic [pas_pkg::STEP_W-1:0] aging_step;
  logic [pas_pkg::QUANT_W-1:0] quantum_ticks;

  logic [CNT_W-1:0] idx;
  logic found;
  logic [pas_pkg::SLOT_W-1:0] best;

  logic we;
  logic [IDX_W-1:0] waddr, raddr;
  logic [pas_pkg::SLOT_W-1:0] wdata, rdata;

  logic signed [pas_pkg::DPRIO_W:0] aged;
  logic [pas_pkg::SLOT_W-1:0] tgt;

  pas_order #(.DEPTH(LIST_DEPTH)) u_order (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wdata),
    .raddr(raddr), .rdata(rdata)
  );

  assign busy = (state != S_IDLE);
  assign raddr = idx[IDX_W-1:0];
  assign tgt = op_cur ? running_slot : op_slot;
  assign aged = {dynamic_prio[rdata][pas_pkg::DPRIO_W-1], dynamic_prio[rdata]}
              - $signed({1'b0, {(pas_pkg::DPRIO_W-pas_pkg::STEP_W){1'b0}}, aging_step});

  always_comb begin
    we = 1'b0;
    waddr = task_count[IDX_W-1:0];
    wdata = op_slot;
    if (state == S_EXEC && op_kind == pas_pkg::KIND_ADD && !slot_present[op_slot]
        && task_count < CNT_MAX) begin
      we = 1'b1;
    end else if (state == S_RM_MOV && found) begin
      we = 1'b1;
      waddr = IDX_W'(idx - 1'b1);
      wdata = rdata;
    end
  end

  always_ff @(posedge clk) begin
    done <= 1'b0;
    if (rst) begin
      state <= S_IDLE;
      slot_present <= '0;
      task_count <= '0;
      running_slot <= '0;
      running_valid <= 1'b0;
      quantum_left <= pas_pkg::QUANT_RESET;
      aging_step <= pas_pkg::AGING_RESET;
      quantum_ticks <= pas_pkg::QUANT_RESET;
      idx <= '0;
      found <= 1'b0;
    end else begin
      if (cfg_we) begin
        if (cfg_index == pas_pkg::CFG_AGING) begin
          aging_step <= cfg_data[pas_pkg::STEP_W-1:0];
        end else begin
          quantum_ticks <= cfg_data[pas_pkg::QUANT_W-1:0];
        end
      end
      unique case (state)
        S_IDLE: begin
          if (start) begin
            op_kind <= kind;
            op_slot <= slot;
            op_cur <= use_current;
            op_prio <= prio;
            state <= S_EXEC;
          end
        end
        S_EXEC: begin
          status <= pas_pkg::ST_OK;
          chosen_valid <= 1'b0;
          chosen_slot <= '0;
          preempt <= 1'b0;
          idx <= '0;
          found <= 1'b0;
          state <= S_READBACK;
          case (op_kind)
            pas_pkg::KIND_ADD: begin
              if (slot_present[op_slot]) begin
                status <= pas_pkg::ST_SLOT;
              end else if (task_count >= CNT_MAX) begin
                status <= pas_pkg::ST_FULL;
              end else begin
                slot_present[op_slot] <= 1'b1;
                static_prio[op_slot] <= '0;
                dynamic_prio[op_slot] <= '0;
                task_count <= task_count + 1'b1;
              end
            end
            pas_pkg::KIND_REMOVE: begin
              if (!slot_present[op_slot]) begin
                status <= pas_pkg::ST_SLOT;
              end else begin
                state <= S_RM_RD;
              end
            end
            pas_pkg::KIND_SETPRI: begin
              if (op_prio < pas_pkg::PRIO_MIN || op_prio > pas_pkg::PRIO_MAX) begin
                status <= pas_pkg::ST_BADPRI;
              end else if (op_cur && !running_valid) begin
                status <= pas_pkg::ST_NOTASK;
              end else if (!slot_present[tgt]) begin
                status <= pas_pkg::ST_SLOT;
              end else begin
                static_prio[tgt] <= op_prio;
                dynamic_prio[tgt] <= pas_pkg::DPRIO_W'(op_prio);
              end
            end
            pas_pkg::KIND_SCHED: begin
              if (task_count == '0) begin
                status <= pas_pkg::ST_NOTASK;
              end else begin
                state <= S_MIN_RD;
              end
            end
            pas_pkg::KIND_TICK: begin
              if (running_valid) begin
                if (quantum_left <= 8'd1) begin
                  quantum_left <= '0;
                  preempt <= 1'b1;
                  running_valid <= 1'b0;
                end else begin
                  quantum_left <= quantum_left - 1'b1;
                end
              end
            end
            default: ;
          endcase
        end
        S_MIN_RD: state <= S_MIN_CMP;
        S_MIN_CMP: begin
          if (idx == '0 || dynamic_prio[rdata] < dynamic_prio[best]) begin
            best <= rdata;
          end
          if (idx + 1'b1 >= task_count) begin
            idx <= '0;
            state <= S_AGE_RD;
          end else begin
            idx <= idx + 1'b1;
            state <= S_MIN_RD;
          end
        end
        S_AGE_RD: state <= S_AGE_UPD;
        S_AGE_UPD: begin
          if (rdata != best) begin
            dynamic_prio[rdata] <= (aged < $signed({pas_pkg::DYN_FLOOR[pas_pkg::DPRIO_W-1],
                                     pas_pkg::DYN_FLOOR})) ? pas_pkg::DYN_FLOOR
                                     : aged[pas_pkg::DPRIO_W-1:0];
          end
          if (idx + 1'b1 >= task_count) begin
            dynamic_prio[best] <= pas_pkg::DPRIO_W'(static_prio[best]);
            running_slot <= best;
            running_valid <= 1'b1;
            quantum_left <= quantum_ticks;
            chosen_valid <= 1'b1;
            chosen_slot <= best;
            state <= S_READBACK;
          end else begin
            idx <= idx + 1'b1;
            state <= S_AGE_RD;
          end
        end
        S_RM_RD: state <= S_RM_MOV;
        S_RM_MOV: begin
          if (rdata == op_slot) begin
            found <= 1'b1;
          end
          if (idx + 1'b1 >= task_count) begin
            task_count <= task_count - 1'b1;
            slot_present[op_slot] <= 1'b0;
            if (running_valid && running_slot == op_slot) begin
              running_valid <= 1'b0;
            end
            state <= S_READBACK;
          end else begin
            idx <= idx + 1'b1;
            state <= S_RM_RD;
          end
        end
        S_READBACK: begin
          prio_readback <= '0;
          if (op_cur) begin
            if (running_valid && slot_present[running_slot]) begin
              prio_readback <= static_prio[running_slot];
            end
          end else if (slot_present[op_slot]) begin
            prio_readback <= static_prio[op_slot];
          end
          done <= 1'b1;
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// ===== rtl/pas_checker.sv =====
// Port-level checks for the scheduler core, bound into the core module.
module pas_checker (
  input logic                               clk,
  input logic                               rst,
  input logic                               start,
  input logic                               busy,
  input logic                               done,
  input logic [pas_pkg::STAT_W-1:0]         status,
  input logic                               chosen_valid,
  input logic                               preempt
);

  a_done_clears_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy) else $error("done while busy");

  a_start_sets_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy) else $error("request not taken");

  a_chosen_ok: assert property (@(posedge clk) disable iff (rst)
    (done && chosen_valid) |-> (status == pas_pkg::ST_OK && !preempt))
    else $error("chosen with error or preempt");

  a_done_pulse: assert property (@(posedge clk) disable iff (rst)
    done |=> !done) else $error("done held");

endmodule

bind priority_aging_scheduler_core pas_checker u_pas_checker (
  .clk(clk), .rst(rst), .start(start), .busy(busy), .done(done),
  .status(status), .chosen_valid(chosen_valid), .preempt(preempt)
);

// ===== tb/sv/testbench.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for the priority aging scheduler core.
module testbench;
  import pas_pkg::*;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  logic [KIND_W-1:0] kind = '0;
  logic [SLOT_W-1:0] slot = '0;
  logic use_current = 1'b0;
  logic signed [SPRIO_W-1:0] prio = '0;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic done;
  logic [STAT_W-1:0] status;
  logic chosen_valid;
  logic [SLOT_W-1:0] chosen_slot;
  logic preempt;
  logic signed [SPRIO_W-1:0] prio_readback;

  typedef struct packed {
    logic [STAT_W-1:0] status;
    logic chosen_valid;
    logic [SLOT_W-1:0] chosen_slot;
    logic preempt;
    logic signed [SPRIO_W-1:0] readback;
  } sched_result_t;

  priority_aging_scheduler_core dut (.*);

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Scheduler mirror
  logic signed [SPRIO_W-1:0] m_static [NSLOTS];
  logic signed [DPRIO_W-1:0] m_dyn [NSLOTS];
  logic m_present [NSLOTS];
  logic [SLOT_W-1:0] m_order [NSLOTS];
  int unsigned m_count;
  logic [SLOT_W-1:0] m_run_slot;
  logic m_run_valid;
  logic [QUANT_W-1:0] m_quant_left;
  logic [STEP_W-1:0] m_aging;
  logic [QUANT_W-1:0] m_quantum;

  sched_result_t pending_results[$];
  int mismatches = 0;
  int results_seen = 0;
  int requests_sent = 0;
  int chosen_seen = 0;
  int preempts_seen = 0;
  int send_idle_pct = 0;

  function automatic sched_result_t predict_request(logic [KIND_W-1:0] k, logic [SLOT_W-1:0] s,
                                                    logic cur, logic signed [SPRIO_W-1:0] p);
    sched_result_t r;
    logic [SLOT_W-1:0] best, t;
    int i, idx, d;
    r = '0;
    case (k)
      KIND_ADD: begin
        if (m_present[s]) r.status = ST_SLOT;
        else if (m_count >= NSLOTS) r.status = ST_FULL;
        else begin
          m_present[s] = 1'b1;
          m_static[s] = '0;
          m_dyn[s] = '0;
          m_order[m_count] = s;
          m_count++;
        end
      end
      KIND_REMOVE: begin
        if (!m_present[s]) r.status = ST_SLOT;
        else begin
          idx = -1;
          for (i = 0; i < m_count; i++) if (idx < 0 && m_order[i] == s) idx = i;
          if (idx >= 0) for (i = idx; i + 1 < m_count; i++) m_order[i] = m_order[i+1];
          m_count--;
          m_present[s] = 1'b0;
          if (m_run_valid && m_run_slot == s) m_run_valid = 1'b0;
        end
      end
      KIND_SETPRI: begin
        if (p < PRIO_MIN || p > PRIO_MAX) r.status = ST_BADPRI;
        else if (cur && !m_run_valid) r.status = ST_NOTASK;
        else begin
          t = cur ? m_run_slot : s;
          if (!m_present[t]) r.status = ST_SLOT;
          else begin
            m_static[t] = p;
            m_dyn[t] = DPRIO_W'(p);
          end
        end
      end
      KIND_SCHED: begin
        if (m_count == 0) r.status = ST_NOTASK;
        else begin
          best = m_order[0];
          for (i = 1; i < m_count; i++) if (m_dyn[m_order[i]] < m_dyn[best]) best = m_order[i];
          for (i = 0; i < m_count; i++)
            if (m_order[i] != best) begin
              d = int'(m_dyn[m_order[i]]) - int'(m_aging);
              m_dyn[m_order[i]] = (d < -128) ? DYN_FLOOR : DPRIO_W'(d);
            end
          m_dyn[best] = DPRIO_W'(m_static[best]);
          m_run_slot = best;
          m_run_valid = 1'b1;
          m_quant_left = m_quantum;
          r.chosen_valid = 1'b1;
          r.chosen_slot = best;
        end
      end
      KIND_TICK: begin
        if (m_run_valid) begin
          if (m_quant_left <= 1) begin
            m_quant_left = '0;
            r.preempt = 1'b1;
            m_run_valid = 1'b0;
          end else m_quant_left--;
        end
      end
      default: ;
    endcase
    if (cur) begin
      if (m_run_valid && m_present[m_run_slot]) r.readback = m_static[m_run_slot];
    end else if (m_present[s]) r.readback = m_static[s];
    return r;
  endfunction

  task automatic send_request(logic [KIND_W-1:0] k, logic [SLOT_W-1:0] s, logic cur,
                              logic signed [SPRIO_W-1:0] p);
    while (send_idle_pct > 0 && $urandom_range(99, 0) < send_idle_pct) @(posedge clk);
    start <= 1'b1;
    kind <= k;
    slot <= s;
    use_current <= cur;
    prio <= p;
    @(posedge clk);
    while (busy) @(posedge clk);
    pending_results.push_back(predict_request(k, s, cur, p));
    requests_sent++;
    start <= 1'b0;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  task automatic drain_and_configure(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    while (pending_results.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == CFG_AGING) m_aging = val[STEP_W-1:0];
    else m_quantum = val;
  endtask

  always @(posedge clk) begin
    sched_result_t got, want;
    if (!rst && done) begin
      got = '{status, chosen_valid, chosen_slot, preempt, prio_readback};
      results_seen++;
      if (chosen_valid) chosen_seen++;
      if (preempt) preempts_seen++;
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %p", got);
      end else begin
        want = pending_results.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= 10) $display("result mismatch: expected %p, got %p", want, got);
        end
      end
    end
  end

  task automatic test_directed;
    int i;
    send_request(KIND_SCHED, 4'd0, 1'b0, 6'sd0);
    send_request(KIND_TICK, 4'd0, 1'b0, 6'sd0);
    send_request(KIND_SETPRI, 4'd3, 1'b1, 6'sd5);
    send_request(KIND_REMOVE, 4'd3, 1'b0, 6'sd0);
    for (i = 0; i < 16; i++) send_request(KIND_ADD, SLOT_W'(15 - i), 1'b0, 6'sd0);
    send_request(KIND_ADD, 4'd7, 1'b0, 6'sd0);
    send_request(KIND_SETPRI, 4'd2, 1'b0, -6'sd32);
    send_request(KIND_SETPRI, 4'd2, 1'b0, 6'sd31);
    send_request(KIND_SETPRI, 4'd2, 1'b0, -6'sd20);
    send_request(KIND_SETPRI, 4'd2, 1'b0, 6'sd20);
    send_request(KIND_SETPRI, 4'd2, 1'b0, -6'sd19);
    send_request(KIND_SETPRI, 4'd9, 1'b0, 6'sd19);
    send_request(KIND_SCHED, 4'd0, 1'b1, 6'sd0);
    send_request(KIND_SETPRI, 4'd0, 1'b1, 6'sd7);
    send_request(3'd5, 4'd9, 1'b0, 6'sd0);
    send_request(3'd7, 4'd9, 1'b1, 6'sd0);
    send_request(KIND_REMOVE, 4'd2, 1'b0, 6'sd0);
    send_request(KIND_SETPRI, 4'd2, 1'b0, 6'sd1);
  endtask

  task automatic test_quantum_expiry;
    int i;
    drain_and_configure(CFG_QUANTUM, 8'd1);
    send_request(KIND_SCHED, 4'd0, 1'b0, 6'sd0);
    send_request(KIND_TICK, 4'd0, 1'b1, 6'sd0);
    send_request(KIND_TICK, 4'd0, 1'b1, 6'sd0);
    drain_and_configure(CFG_QUANTUM, 8'd3);
    send_request(KIND_SCHED, 4'd0, 1'b0, 6'sd0);
    for (i = 0; i < 4; i++) send_request(KIND_TICK, 4'd0, 1'b0, 6'sd0);
    drain_and_configure(CFG_QUANTUM, 8'd0);
    send_request(KIND_SCHED, 4'd0, 1'b0, 6'sd0);
    send_request(KIND_TICK, 4'd0, 1'b0, 6'sd0);
  endtask

  task automatic test_random(int n);
    int i;
    logic [KIND_W-1:0] k;
    int sel;
    for (i = 0; i < n; i++) begin
      sel = $urandom_range(99, 0);
      if (sel < 18) k = KIND_ADD;
      else if (sel < 30) k = KIND_REMOVE;
      else if (sel < 52) k = KIND_SETPRI;
      else if (sel < 72) k = KIND_SCHED;
      else if (sel < 97) k = KIND_TICK;
      else k = KIND_W'($urandom_range(7, 5));
      send_request(k, SLOT_W'($urandom), 1'($urandom_range(3, 0) == 0),
                   ($urandom_range(4, 0) == 0) ? SPRIO_W'($urandom)
                                                 : SPRIO_W'($urandom_range(38, 0) - 19));
    end
  endtask

  initial begin
    int i;
    for (i = 0; i < NSLOTS; i++) begin
      m_static[i] = '0;
      m_dyn[i] = '0;
      m_present[i] = 1'b0;
      m_order[i] = '0;
    end
    m_count = 0;
    m_run_slot = '0;
    m_run_valid = 1'b0;
    m_quant_left = QUANT_RESET;
    m_aging = AGING_RESET;
    m_quantum = QUANT_RESET;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_quantum_expiry();
    drain_and_configure(CFG_AGING, 4'd15);
    drain_and_configure(CFG_QUANTUM, 8'd255);
    send_idle_pct = 27;
    test_random(330);
    drain_and_configure(CFG_AGING, 4'd0);
    drain_and_configure(CFG_QUANTUM, 8'd4);
    send_idle_pct = 79;
    test_random(330);
    drain_and_configure(CFG_AGING, 4'd6);
    drain_and_configure(CFG_QUANTUM, 8'd2);
    send_idle_pct = 0;
    test_random(340);
    while (pending_results.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    $display("Sent %0d requests, checked %0d results (%0d schedules chose a task, %0d preempts).",
             requests_sent, results_seen, chosen_seen, preempts_seen);
    if (mismatches == 0) $display("No mismatches found");
    else $display("Mismatches found");
    $finish;
  end

  initial begin
    #20ms;
    $display("Timeout with %0d results outstanding", pending_results.size());
    $display("Mismatches found");
    $finish;
  end

endmodule
